@@ rtl/rmth_pkg.sv @@
// shared constants and types for the running median block
package rmth_pkg;

  localparam int unsigned HeapDepth = 512;
  localparam int unsigned DataW     = 32;
  localparam int unsigned AddrW     = $clog2(HeapDepth);
  localparam int unsigned CntW      = $clog2(HeapDepth + 1);
  localparam int unsigned IdxW      = AddrW + 2;
  localparam int unsigned SumW      = CntW + 1;
  localparam logic [SumW-1:0] FullCnt = SumW'(2 * HeapDepth - 1);

  // command from the median control to one heap
  typedef struct packed {
    logic                    push;
    logic                    replace;
    logic                    clear;
    logic signed [DataW-1:0] value;
  } heap_cmd_t;

  // status of one heap
  typedef struct packed {
    logic                    busy;
    logic [CntW-1:0]         count;
    logic signed [DataW-1:0] top;
  } heap_stat_t;

endpackage

@@ rtl/rmth_heap.sv @@
// one binary heap in a synchronous memory with push and replace-top sequencers
module rmth_heap import rmth_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       is_max_i,   // 1 for a max-heap, 0 for a min-heap
  input  heap_cmd_t  cmd_i,
  output heap_stat_t stat_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PUSH_RD, ST_PUSH_CMP, ST_DN_L, ST_DN_R, ST_DN_CMP
  } state_e;

  state_e                  state_q, state_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [AddrW-1:0]        idx_q, idx_d;
  logic signed [DataW-1:0] val_q, val_d;
  logic signed [DataW-1:0] left_q, left_d;
  logic                    rvld_q, rvld_d;
  logic signed [DataW-1:0] top_q;

  logic signed [DataW-1:0] mem_q [HeapDepth];
  logic signed [DataW-1:0] rdata_q;
  logic [AddrW-1:0]        raddr;
  logic                    we;
  logic [AddrW-1:0]        waddr;
  logic signed [DataW-1:0] wdata;

  logic [IdxW-1:0]  lidx, ridx;
  logic [AddrW-1:0] pidx;
  logic             l_in, r_in;
  logic             l_best;
  logic signed [DataW-1:0] best_val;

  function automatic logic above(logic signed [DataW-1:0] a,
                                 logic signed [DataW-1:0] b, logic mx);
    return mx ? (a > b) : (a < b);
  endfunction

  // child and parent indexes of the current hole
  assign lidx = {1'b0, idx_q, 1'b1};
  assign ridx = lidx + IdxW'(1);
  assign pidx = AddrW'((idx_q - AddrW'(1)) >> 1);
  assign l_in = lidx < IdxW'(count_q);
  assign r_in = ridx < IdxW'(count_q);

  // sequencer next state and memory port control
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    val_d    = val_q;
    left_d   = left_q;
    rvld_d   = rvld_q;
    raddr    = pidx;
    we       = 1'b0;
    waddr    = idx_q;
    wdata    = val_q;
    l_best   = 1'b0;
    best_val = val_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.clear) begin
          count_d = '0;
        end else if (cmd_i.push) begin
          idx_d   = AddrW'(count_q);
          count_d = count_q + CntW'(1);
          val_d   = cmd_i.value;
          state_d = ST_PUSH_RD;
        end else if (cmd_i.replace) begin
          idx_d   = '0;
          val_d   = cmd_i.value;
          state_d = ST_DN_L;
        end
      end
      ST_PUSH_RD: begin
        if (idx_q == '0) begin
          we      = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_PUSH_CMP;
        end
      end
      ST_PUSH_CMP: begin
        we = 1'b1;
        if (above(val_q, rdata_q, is_max_i)) begin
          wdata   = rdata_q;
          idx_d   = pidx;
          state_d = ST_PUSH_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DN_L: begin
        raddr = AddrW'(lidx);
        if (l_in) begin
          state_d = ST_DN_R;
        end else begin
          we      = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_DN_R: begin
        raddr   = AddrW'(ridx);
        left_d  = rdata_q;
        rvld_d  = r_in;
        state_d = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        we = 1'b1;
        if (above(left_q, val_q, is_max_i)) begin
          l_best   = 1'b1;
          best_val = left_q;
        end
        if (rvld_q && above(rdata_q, best_val, is_max_i)) begin
          wdata   = rdata_q;
          idx_d   = AddrW'(ridx);
          state_d = ST_DN_L;
        end else if (l_best) begin
          wdata   = left_q;
          idx_d   = AddrW'(lidx);
          state_d = ST_DN_L;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state, count and mirrored top entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    val_q  <= val_d;
    left_q <= left_d;
    rvld_q <= rvld_d;
    if (we && waddr == '0) begin
      top_q <= wdata;
    end
  end

  // heap storage, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign stat_o.busy  = state_q != ST_IDLE;
  assign stat_o.count = count_q;
  assign stat_o.top   = top_q;

endmodule

@@ rtl/running_median_two_heaps.sv @@
// running lower median of a sample stream kept with a max-heap and a min-heap
// result: the result item is registered and offered in the cycle after its input item is accepted
// throughput: one item per cycle for a stream start or a dropped item, others wait for
//   the heap sift walk (per level, push: parent read and compare; replace-top: left
//   read, right read and compare); a stalled result item holds off the next input item
// reset: median 0, both heaps empty; heap memories are not cleared
module running_median_two_heaps import rmth_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] sample
  input  logic        s_axis_tuser_i,   // [0] stream_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] median
  output logic        m_axis_tuser_o    // [0] dropped
);

  heap_cmd_t  lo_cmd, up_cmd;
  heap_stat_t lo_st, up_st;

  logic signed [DataW-1:0] median_q, median_d;
  logic signed [DataW-1:0] smp;
  logic                    drop_d;
  logic                    ovld_q;
  logic signed [DataW-1:0] odata_q;
  logic                    odrop_q;
  logic                    acc;
  logic [SumW-1:0]         total;

  rmth_heap u_lower (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .is_max_i (1'b1),
    .cmd_i    (lo_cmd),
    .stat_o   (lo_st)
  );

  rmth_heap u_upper (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .is_max_i (1'b0),
    .cmd_i    (up_cmd),
    .stat_o   (up_st)
  );

  assign s_axis_tready_o = !lo_st.busy && !up_st.busy && (!ovld_q || m_axis_tready_i);
  assign acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign smp   = s_axis_tdata_i;
  assign total = SumW'(lo_st.count) + SumW'(up_st.count);

  // decide median and heap commands for an accepted item
  always_comb begin
    lo_cmd   = '0;
    up_cmd   = '0;
    median_d = median_q;
    drop_d   = 1'b0;
    lo_cmd.value = smp;
    up_cmd.value = smp;
    if (s_axis_tuser_i) begin
      lo_cmd.clear = acc;
      up_cmd.clear = acc;
      median_d     = smp;
    end else if (total >= FullCnt) begin
      drop_d = 1'b1;
    end else if (smp < median_q) begin
      if (lo_st.count == up_st.count) begin
        up_cmd.push  = acc;
        up_cmd.value = median_q;
        if (lo_st.count == '0 || smp >= lo_st.top) begin
          median_d = smp;
        end else begin
          median_d       = lo_st.top;
          lo_cmd.replace = acc;
        end
      end else begin
        lo_cmd.push = acc;
      end
    end else begin
      if (up_st.count == lo_st.count + CntW'(1)) begin
        lo_cmd.push  = acc;
        lo_cmd.value = median_q;
        if (up_st.count == '0 || smp <= up_st.top) begin
          median_d = smp;
        end else begin
          median_d       = up_st.top;
          up_cmd.replace = acc;
        end
      end else begin
        up_cmd.push = acc;
      end
    end
  end

  // median register and output item register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      median_q <= '0;
      ovld_q   <= 1'b0;
    end else begin
      if (acc) begin
        median_q <= median_d;
        ovld_q   <= 1'b1;
      end else if (m_axis_tready_i) begin
        ovld_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      odata_q <= median_d;
      odrop_q <= drop_d;
    end
  end

  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tuser_o  = odrop_q;

endmodule

@@ test/running_median_two_heaps_test.sv @@
// testbench for the two-heap running median block: predicts each median and checks it
module running_median_two_heaps_test;
  import rmth_pkg::*;

  localparam int unsigned Depth = HeapDepth;
  localparam int unsigned Limit = 2000000;

  // expected result of one item
  typedef struct {
    logic signed [31:0] median;
    logic               dropped;
  } median_res_t;

  // predictor and store of expected medians
  class median_board;
    logic signed [31:0] cur_median;
    logic signed [31:0] lo_heap [Depth];
    logic signed [31:0] hi_heap [Depth];
    int unsigned lo_cnt, hi_cnt;
    median_res_t pending [$];
    int errors;

    function new();
      cur_median = 0;
      lo_cnt = 0;
      hi_cnt = 0;
      errors = 0;
    endfunction

    // heap on the lower side keeps the max on top, upper side the min
    function bit above(logic signed [31:0] a, logic signed [31:0] b, bit is_max);
      return is_max ? (a > b) : (a < b);
    endfunction

    function void push_lo(logic signed [31:0] v);
      int unsigned i, p;
      logic signed [31:0] t;
      i = lo_cnt;
      lo_heap[i] = v;
      lo_cnt++;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (!above(lo_heap[i], lo_heap[p], 1)) break;
        t = lo_heap[i]; lo_heap[i] = lo_heap[p]; lo_heap[p] = t;
        i = p;
      end
    endfunction

    function void push_hi(logic signed [31:0] v);
      int unsigned i, p;
      logic signed [31:0] t;
      i = hi_cnt;
      hi_heap[i] = v;
      hi_cnt++;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (!above(hi_heap[i], hi_heap[p], 0)) break;
        t = hi_heap[i]; hi_heap[i] = hi_heap[p]; hi_heap[p] = t;
        i = p;
      end
    endfunction

    function void sift_lo(logic signed [31:0] v);
      int unsigned i, l, r, b;
      logic signed [31:0] t;
      i = 0;
      lo_heap[0] = v;
      forever begin
        l = 2 * i + 1; r = l + 1; b = i;
        if (l < lo_cnt && above(lo_heap[l], lo_heap[b], 1)) b = l;
        if (r < lo_cnt && above(lo_heap[r], lo_heap[b], 1)) b = r;
        if (b == i) break;
        t = lo_heap[i]; lo_heap[i] = lo_heap[b]; lo_heap[b] = t;
        i = b;
      end
    endfunction

    function void sift_hi(logic signed [31:0] v);
      int unsigned i, l, r, b;
      logic signed [31:0] t;
      i = 0;
      hi_heap[0] = v;
      forever begin
        l = 2 * i + 1; r = l + 1; b = i;
        if (l < hi_cnt && above(hi_heap[l], hi_heap[b], 0)) b = l;
        if (r < hi_cnt && above(hi_heap[r], hi_heap[b], 0)) b = r;
        if (b == i) break;
        t = hi_heap[i]; hi_heap[i] = hi_heap[b]; hi_heap[b] = t;
        i = b;
      end
    endfunction

    // note one accepted sample and queue its expected median
    function void note_sample(logic signed [31:0] s, logic start);
      median_res_t r;
      logic signed [31:0] m;
      r.dropped = 0;
      m = cur_median;
      if (start) begin
        lo_cnt = 0;
        hi_cnt = 0;
        cur_median = s;
      end else if (lo_cnt + hi_cnt >= 2 * Depth - 1) begin
        r.dropped = 1;
      end else if (s < m) begin
        if (lo_cnt == hi_cnt) begin
          push_hi(m);
          if (lo_cnt == 0 || s >= lo_heap[0]) cur_median = s;
          else begin
            cur_median = lo_heap[0];
            sift_lo(s);
          end
        end else push_lo(s);
      end else begin
        if (hi_cnt == lo_cnt + 1) begin
          push_lo(m);
          if (hi_cnt == 0 || s <= hi_heap[0]) cur_median = s;
          else begin
            cur_median = hi_heap[0];
            sift_hi(s);
          end
        end else push_hi(s);
      end
      r.median = cur_median;
      pending.insert(pending.size(), r);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(logic signed [31:0] med, logic drop);
      median_res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result median %0d dropped %0b", med, drop);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (med !== e.median) begin
        $error("median: expected %0d actual %0d", e.median, med);
        errors++;
      end
      if (drop !== e.dropped) begin
        $error("dropped: expected %0b actual %0b", e.dropped, drop);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid_i = 0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;   // [31:0] sample
  logic        s_axis_tuser_i = 0;    // [0] stream_start
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 0;
  logic [31:0] m_axis_tdata_o;        // [31:0] median
  logic        m_axis_tuser_o;        // [0] dropped

  median_board board = new();
  int send_idle = 12;
  int recv_idle = 48;
  int unsigned cycles = 0;

  running_median_two_heaps uut (.*);

  // clock
  always #10 clk_i = ~clk_i;

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver with random stall
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      board.check_result($signed(m_axis_tdata_o), m_axis_tuser_o);
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle);
  end

  // send one item, with random idle cycles ahead of it
  task automatic send_item(logic signed [31:0] s, logic start);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid_i <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tdata_i <= s;
    s_axis_tuser_i <= start;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    board.note_sample(s, start);
  endtask

  // random sample, often from a narrow range so equal values occur
  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(3))
      0: return $signed(32'($urandom_range(20)) - 10);
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom());
    endcase
  endfunction

  // random stream of given length
  task automatic send_stream(int n);
    send_item(rand_sample(), 1);
    for (int i = 1; i < n; i++) send_item(rand_sample(), $urandom_range(199) == 0);
  endtask

  // stop sending and wait for every expected item
  task automatic drain();
    s_axis_tvalid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: no start after reset, extremes, equal to median
    send_item(32'sh80000000, 0);
    send_item(32'sh7fffffff, 0);
    send_item(0, 0);
    send_item(0, 0);
    send_item(-1, 0);
    send_item(32'sh80000000, 1);
    send_item(32'sh80000000, 0);
    send_item(32'sh7fffffff, 0);
    send_item(5, 0);
    send_item(-5, 0);
    send_item(3, 0);
    send_item(7, 1);
    send_item(7, 0);
    send_item(1, 0);
    send_item(9, 0);
    send_item(8, 0);
    send_item(2, 0);
    send_item(32'h55555555, 0);
    send_item(32'haaaaaaaa, 0);
    // pause until all results are in
    drain();
    // full stream: fill past capacity, then drops and a restart
    send_item(rand_sample(), 1);
    for (int i = 1; i < 2 * Depth + 4; i++) send_item(rand_sample(), 0);
    send_item(4, 1);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 12 : (ph == 1) ? 48 : 0;
      recv_idle = (ph == 0) ? 48 : (ph == 1) ? 12 : 0;
      repeat (6) send_stream($urandom_range(2, 40));
      send_stream($urandom_range(100, 200));
      if (ph == 1) drain();
    end
    drain();
    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
